>>> hw/rtl/ansi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_pkg - shared types and constants for the escape-sequence parser
// Character codes, action codes, parameter entry layout and the color
// reorder table used by the SGR update unit and the sequencer.
// ----------------------------------------------------------------------------
package ansi_pkg;

    // Text attribute: [6:4] background, [3] bright, [2:0] foreground (RGB)
    typedef logic [6:0] attr_t;

    // Parameter entry: [8] empty mark, [7:0] value
    typedef logic [8:0] param_t;

    localparam int PARAM_W = 9;
    localparam param_t PARAM_EMPTY = 9'h100;
    localparam param_t PARAM_ZERO  = 9'h000;

    // Action codes on the result channel
    localparam logic [2:0] ACT_PRINT     = 3'd0;
    localparam logic [2:0] ACT_BACKSPACE = 3'd1;
    localparam logic [2:0] ACT_SET_ATTR  = 3'd2;
    localparam logic [2:0] ACT_CLEAR     = 3'd3;
    localparam logic [2:0] ACT_REFRESH   = 3'd4;

    // Character codes
    localparam logic [7:0] CHAR_ESC     = 8'h1B;
    localparam logic [7:0] CHAR_BS      = 8'h08;
    localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHAR_GREATER = 8'h3E;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_LOWER_M = 8'h6D;
    localparam logic [7:0] CHAR_UPPER_J = 8'h4A;
    localparam logic [7:0] CHAR_LOWER_L = 8'h6C;

    // SGR code ranges
    localparam logic [7:0] SGR_RESET  = 8'd0;
    localparam logic [7:0] SGR_BRIGHT = 8'd1;
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;

    localparam logic [2:0] FG_DEFAULT = 3'd7;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

    // Map a BGR color index to RGB bit order
    function automatic logic [2:0] bgr_to_rgb(input logic [2:0] idx);
        logic [2:0] rgb;
        case (idx)
            3'd0:    rgb = 3'd0;
            3'd1:    rgb = 3'd4;
            3'd2:    rgb = 3'd2;
            3'd3:    rgb = 3'd6;
            3'd4:    rgb = 3'd1;
            3'd5:    rgb = 3'd5;
            3'd6:    rgb = 3'd3;
            3'd7:    rgb = 3'd7;
            default: rgb = 3'd0;
        endcase
        return rgb;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ansi_escape_to_text_attribute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_escape_to_text_attribute - console escape-sequence parser
// Turns a character stream into print, backspace, attribute, clear-screen
// and cursor-refresh requests, tracking the SGR text attribute.
// ----------------------------------------------------------------------------
// Each character's request (if any) is registered and shown on the m_
// channel the cycle after acceptance. The final 'm' of a sequence walks
// the stored parameters (up to MAX_PARAMS) through a single SGR update
// unit, with a memory read state and then an apply state per parameter.
// s_ready stays low during the walk and while an undelivered request blocks
// the output register. Writing cfg_wdata sets the current attribute at once.
// ----------------------------------------------------------------------------
module ansi_escape_to_text_attribute #(
    parameter int MAX_PARAMS = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    // configuration
    input  wire        cfg_we,
    input  wire [6:0]  cfg_wdata,
    // character requests
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [7:0]  s_in_char,
    // result requests
    output logic       m_valid,
    input  wire        m_ready,
    output logic [2:0] m_action,
    output logic [7:0] m_out_char,
    output logic [6:0] m_attribute
);
    import ansi_pkg::*;

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARAMS - 1);
    localparam attr_t ATTR_RESET = 7'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_APPLY
    } state_t;

    state_t           state_reg, state_next;
    logic             in_seq_reg, in_seq_next;
    logic             gt_reg, gt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    param_t           acc_reg, acc_next;
    attr_t            cur_attr_reg, cur_attr_next;
    attr_t            walk_attr_reg, walk_attr_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_action_reg, m_action_next;
    logic [7:0]       m_char_reg, m_char_next;
    attr_t            m_attr_reg, m_attr_next;

    logic             accept;
    logic             mem_we;
    logic             mem_re;
    param_t           mem_rdata;
    attr_t            sgr_attr;
    logic             is_digit;
    logic             is_letter;
    logic [11:0]      acc_scaled;

    // Parameter store and the shared SGR unit
    ansi_param_mem #(
        .DEPTH  (MAX_PARAMS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (acc_reg),
        .rd_en   (mem_re),
        .rd_addr (walk_reg),
        .rd_data (mem_rdata)
    );

    ansi_sgr_unit u_sgr (
        .attr_in  (walk_attr_reg),
        .param    (mem_rdata),
        .attr_out (sgr_attr)
    );

    // Take a character only when idle and the output slot frees up
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Classify the incoming character
    always_comb begin
        is_digit  = 1'b0;
        is_letter = 1'b0;
        case (s_in_char) inside
            [8'h30:8'h39]: is_digit  = 1'b1;
            [8'h41:8'h5A],
            [8'h61:8'h7A]: is_letter = 1'b1;
            default: ;
        endcase
    end

    // Decimal accumulate: value * 10 + digit
    assign acc_scaled = ({4'b0, acc_reg[7:0]} << 3) + ({4'b0, acc_reg[7:0]} << 1)
                      + {8'b0, s_in_char[3:0]};

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        in_seq_next    = in_seq_reg;
        gt_next        = gt_reg;
        idx_next       = idx_reg;
        walk_next      = walk_reg;
        acc_next       = acc_reg;
        cur_attr_next  = cur_attr_reg;
        walk_attr_next = walk_attr_reg;
        m_valid_next   = m_valid_reg;
        m_action_next  = m_action_reg;
        m_char_next    = m_char_reg;
        m_attr_next    = m_attr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        // drop a delivered request
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_seq_reg) begin
                        if (s_in_char == CHAR_ESC) begin
                            in_seq_next = 1'b1;
                            gt_next     = 1'b0;
                            idx_next    = '0;
                            acc_next    = PARAM_ZERO;
                        end else if (s_in_char == CHAR_BS) begin
                            m_valid_next  = 1'b1;
                            m_action_next = ACT_BACKSPACE;
                            m_char_next   = 8'd0;
                            m_attr_next   = cur_attr_reg;
                        end else begin
                            m_valid_next  = 1'b1;
                            m_action_next = ACT_PRINT;
                            m_char_next   = s_in_char;
                            m_attr_next   = cur_attr_reg;
                        end
                    end else if (s_in_char == CHAR_LBRACK) begin
                        in_seq_next = 1'b1;
                    end else if (s_in_char == CHAR_GREATER) begin
                        gt_next = 1'b1;
                    end else if (is_digit) begin
                        if (acc_reg[8]) begin
                            acc_next = {5'b0, s_in_char[3:0]};
                        end else if (acc_scaled > 12'd255) begin
                            acc_next = {1'b0, 8'hFF};
                        end else begin
                            acc_next = {1'b0, acc_scaled[7:0]};
                        end
                    end else if (s_in_char == CHAR_SEMI) begin
                        // close the current parameter unless the store is full
                        if (idx_reg != LAST_IDX) begin
                            mem_we   = 1'b1;
                            idx_next = idx_reg + 1'b1;
                            acc_next = PARAM_EMPTY;
                        end
                    end else begin
                        in_seq_next = 1'b0;
                        idx_next    = '0;
                        if (is_letter && s_in_char == CHAR_LOWER_M) begin
                            // store the last parameter and start the walk
                            mem_we         = 1'b1;
                            idx_next       = idx_reg;
                            walk_next      = '0;
                            walk_attr_next = cur_attr_reg;
                            state_next     = ST_READ;
                        end else if (is_letter && s_in_char == CHAR_UPPER_J) begin
                            m_valid_next  = 1'b1;
                            m_action_next = ACT_CLEAR;
                            m_char_next   = 8'd0;
                            m_attr_next   = cur_attr_reg;
                        end else if (is_letter && s_in_char == CHAR_LOWER_L && gt_reg) begin
                            m_valid_next  = 1'b1;
                            m_action_next = ACT_REFRESH;
                            m_char_next   = 8'd0;
                            m_attr_next   = cur_attr_reg;
                        end
                    end
                end
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                walk_attr_next = sgr_attr;
                if (walk_reg == idx_reg) begin
                    // last parameter: commit and emit the attribute
                    cur_attr_next = sgr_attr;
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_SET_ATTR;
                    m_char_next   = 8'd0;
                    m_attr_next   = sgr_attr;
                    idx_next      = '0;
                    state_next    = ST_IDLE;
                end else begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration write loads the attribute
        if (cfg_we) begin
            cur_attr_next = cfg_wdata;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_seq_reg   <= 1'b0;
            gt_reg       <= 1'b0;
            idx_reg      <= '0;
            cur_attr_reg <= ATTR_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_seq_reg   <= in_seq_next;
            gt_reg       <= gt_next;
            idx_reg      <= idx_next;
            cur_attr_reg <= cur_attr_next;
            m_valid_reg  <= m_valid_next;
        end
        walk_reg      <= walk_next;
        acc_reg       <= acc_next;
        walk_attr_reg <= walk_attr_next;
        m_action_reg  <= m_action_next;
        m_char_reg    <= m_char_next;
        m_attr_reg    <= m_attr_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_action    = m_action_reg;
    assign m_out_char  = m_char_reg;
    assign m_attribute = m_attr_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ansi_sgr_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_sgr_unit - apply one SGR parameter to a text attribute
// Shared compare-and-map unit; the sequencer feeds it one stored
// parameter per step and keeps the running attribute.
// ----------------------------------------------------------------------------
module ansi_sgr_unit (
    input  wire ansi_pkg::attr_t  attr_in,
    input  wire ansi_pkg::param_t param,
    output ansi_pkg::attr_t       attr_out
);
    import ansi_pkg::*;

    logic [2:0] fg;
    logic [2:0] bg;
    logic       hi;
    logic [7:0] val;
    logic [7:0] fg_off;

    assign val    = param[7:0];
    assign fg_off = val - SGR_FG_LO;

    // Update the color fields for one code; skip empty entries
    always_comb begin
        fg = attr_in[2:0];
        hi = attr_in[3];
        bg = attr_in[6:4];
        if (!param[8]) begin
            case (val) inside
                [SGR_FG_LO:SGR_FG_HI]: fg = bgr_to_rgb(fg_off[2:0]);
                [SGR_BG_LO:SGR_BG_HI]: bg = bgr_to_rgb(val[2:0]);
                SGR_BRIGHT:            hi = 1'b1;
                SGR_RESET: begin
                    fg = FG_DEFAULT;
                    bg = BG_DEFAULT;
                    hi = 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign attr_out = {bg, hi, fg};

endmodule
`default_nettype wire

>>> hw/rtl/ansi_param_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_param_mem - parameter store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ansi_param_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire                    aclk,
    input  wire                    wr_en,
    input  wire [ADDR_W-1:0]       wr_addr,
    input  wire ansi_pkg::param_t  wr_data,
    input  wire                    rd_en,
    input  wire [ADDR_W-1:0]       rd_addr,
    output ansi_pkg::param_t       rd_data
);
    import ansi_pkg::*;

    param_t mem [DEPTH];
    param_t rd_data_reg;

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire
